// ===== rtl/core/crg_pkg.sv =====
// Shared types, constants and helpers for the camera ray generator.
package crg_pkg;

  localparam int COMP_W   = 16;
  localparam int VEC_W    = 3 * COMP_W;
  localparam int UV_W     = 17;
  localparam int ORG_W    = 24;
  localparam int DIR_W    = 16;
  localparam int MAG_W    = 30;
  localparam int WIDE_W   = 64;
  localparam int SUM_W    = 2 * MAG_W + 2;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int QUO_W    = 15;
  localparam int FRAC_SH  = 14;
  localparam int CFG_IDX_W = 3;

  localparam logic [COMP_W-1:0] EXTENT_RST = 16'd4096;
  localparam logic [COMP_W-1:0] FOCAL_RST  = 16'd40960;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_EYE,
    REG_VIEW,
    REG_RIGHT,
    REG_UP,
    REG_EXTENT,
    REG_FOCAL
  } crg_reg_t;

  typedef logic [2:0][MAG_W-1:0] crg_mag_t;

  typedef struct packed {
    logic                  valid;
    logic                  persp;
    logic                  zero;
    logic [2:0]            neg;
    logic [2:0][ORG_W-1:0] origin;
    logic [2:0][DIR_W-1:0] odir;
  } crg_meta_t;

  function automatic logic signed [COMP_W-1:0] vec_comp(input logic [VEC_W-1:0] v,
                                                        input int unsigned i);
    vec_comp = $signed(v[COMP_W*i +: COMP_W]);
  endfunction

endpackage

// ===== rtl/core/crg_front.sv =====
// Front end: screen offsets, ray origin, raw direction and block normalization.
module crg_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic [crg_pkg::UV_W-1:0]     pixel_u,
  input  logic [crg_pkg::UV_W-1:0]     pixel_v,
  input  logic                         persp,
  input  logic [crg_pkg::VEC_W-1:0]    eye,
  input  logic [crg_pkg::VEC_W-1:0]    view,
  input  logic [crg_pkg::VEC_W-1:0]    right_ax,
  input  logic [crg_pkg::VEC_W-1:0]    up_ax,
  input  logic [crg_pkg::COMP_W-1:0]   extent,
  input  logic [crg_pkg::COMP_W-1:0]   focal,
  output crg_pkg::crg_meta_t           meta_o,
  output crg_pkg::crg_mag_t            mag_o
);
  import crg_pkg::*;

  localparam int DUE_W  = 35;
  localparam int PROD_W = 51;
  localparam int VF_W   = 33;
  localparam int OFF_W  = 52;
  localparam int D_W    = 53;
  localparam int NSTEP  = 3;

  // stage 1: coordinate offsets times extent
  logic                    v1_r;
  logic signed [17:0]      du, dv;
  logic signed [DUE_W-1:0] due_r, dve_r, due_nxt, dve_nxt;

  always_comb begin
    du      = $signed({1'b0, pixel_u}) - 18'sd32768;
    dv      = $signed({1'b0, pixel_v}) - 18'sd32768;
    due_nxt = du * $signed({1'b0, extent});
    dve_nxt = dv * $signed({1'b0, extent});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
    end
    due_r <= due_nxt;
    dve_r <= dve_nxt;
  end

  // stage 2: scale by the screen axes, view times focal distance
  logic                     v2_r;
  logic signed [PROD_W-1:0] pr_r [3];
  logic signed [PROD_W-1:0] pu_r [3];
  logic signed [VF_W-1:0]   vf_r [3];
  logic signed [PROD_W-1:0] pr_nxt [3];
  logic signed [PROD_W-1:0] pu_nxt [3];
  logic signed [VF_W-1:0]   vf_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_nxt[i] = due_r * vec_comp(right_ax, i);
      pu_nxt[i] = dve_r * vec_comp(up_ax, i);
      vf_nxt[i] = vec_comp(view, i) * $signed({1'b0, focal});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    pr_r <= pr_nxt;
    pu_r <= pu_nxt;
    vf_r <= vf_nxt;
  end

  // stage 3: offset sum and raw perspective direction
  logic                    v3_r;
  logic signed [OFF_W-1:0] off_r [3];
  logic signed [D_W-1:0]   d_r [3];
  logic signed [OFF_W-1:0] off_nxt [3];
  logic signed [D_W-1:0]   d_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off_nxt[i] = pr_r[i] + pu_r[i];
      d_nxt[i]   = $signed({vf_r[i], 16'b0}) + off_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    off_r <= off_nxt;
    d_r   <= d_nxt;
  end

  // stage 4: origin with rounding and saturation, ortho direction, magnitudes
  crg_meta_t                    meta_r [NSTEP+1];
  logic [2:0][WIDE_W-1:0]       nm_r   [NSTEP+1];
  logic [WIDE_W-1:0]            nor_r  [NSTEP+1];
  crg_meta_t                    meta4_nxt;
  logic [2:0][WIDE_W-1:0]       mag4_nxt;
  logic signed [OFF_W:0]        rnd;
  logic signed [ORG_W+1:0]      osum;
  logic signed [17:0]           vd;
  logic [D_W-1:0]               mabs;

  always_comb begin
    meta4_nxt       = '0;
    meta4_nxt.valid = v3_r;
    meta4_nxt.persp = persp;
    for (int i = 0; i < 3; i++) begin
      rnd  = off_r[i] + (53'sd1 <<< 27);
      osum = vec_comp(eye, i) + $signed(rnd[OFF_W:28]);
      if (osum > 26'sd8388607) begin
        meta4_nxt.origin[i] = 24'h7FFFFF;
      end else if (osum < -26'sd8388608) begin
        meta4_nxt.origin[i] = 24'h800000;
      end else begin
        meta4_nxt.origin[i] = osum[ORG_W-1:0];
      end
      if (persp) begin
        meta4_nxt.origin[i] = ORG_W'(vec_comp(eye, i));
      end
      vd = vec_comp(view, i) <<< 2;
      if (vd > 18'sd16384) begin
        meta4_nxt.odir[i] = 16'd16384;
      end else if (vd < -18'sd16384) begin
        meta4_nxt.odir[i] = 16'hC000;
      end else begin
        meta4_nxt.odir[i] = vd[DIR_W-1:0];
      end
      meta4_nxt.neg[i] = d_r[i][D_W-1];
      mabs             = d_r[i][D_W-1] ? D_W'(-d_r[i]) : D_W'(d_r[i]);
      mag4_nxt[i]      = {{(WIDE_W-D_W){1'b0}}, mabs};
    end
    meta4_nxt.zero = (mag4_nxt[0] | mag4_nxt[1] | mag4_nxt[2]) == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r[0] <= '0;
    end else begin
      meta_r[0] <= meta4_nxt;
    end
    nm_r[0]  <= mag4_nxt;
    nor_r[0] <= mag4_nxt[0] | mag4_nxt[1] | mag4_nxt[2];
  end

  // stages 5..7: shift left until the largest magnitude tops bit 63, two steps per stage
  for (genvar s = 0; s < NSTEP; s++) begin : g_norm
    localparam int SH_A = 1 << (5 - 2*s);
    localparam int SH_B = 1 << (4 - 2*s);
    logic [2:0][WIDE_W-1:0] mx;
    logic [WIDE_W-1:0]      ox;

    always_comb begin
      mx = nm_r[s];
      ox = nor_r[s];
      if (ox[WIDE_W-1 -: SH_A] == '0) begin
        ox = ox << SH_A;
        for (int i = 0; i < 3; i++) mx[i] = mx[i] << SH_A;
      end
      if (ox[WIDE_W-1 -: SH_B] == '0) begin
        ox = ox << SH_B;
        for (int i = 0; i < 3; i++) mx[i] = mx[i] << SH_B;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        meta_r[s+1] <= '0;
      end else begin
        meta_r[s+1] <= meta_r[s];
      end
      nm_r[s+1]  <= mx;
      nor_r[s+1] <= ox;
    end
  end

  // top bit at 63 maps to bit 29: truncating right shift or exact left shift
  always_comb begin
    meta_o = meta_r[NSTEP];
    for (int i = 0; i < 3; i++) mag_o[i] = nm_r[NSTEP][i][WIDE_W-1 -: MAG_W];
  end

endmodule

// ===== rtl/core/crg_isqrt.sv =====
// Pipelined sum of squares and integer square root, one root bit per stage.
module crg_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  crg_pkg::crg_meta_t          meta_i,
  input  crg_pkg::crg_mag_t           mag_i,
  output crg_pkg::crg_meta_t          meta_o,
  output crg_pkg::crg_mag_t           mag_o,
  output logic [crg_pkg::ROOT_W-1:0]  root_o
);
  import crg_pkg::*;

  localparam int SQ_W  = 2 * MAG_W;
  localparam int REM_W = ROOT_W + 2;

  crg_meta_t       mq_r;
  crg_mag_t        gq_r;
  logic [SQ_W-1:0] sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mq_r <= '0;
    end else begin
      mq_r <= meta_i;
    end
    gq_r <= mag_i;
    for (int i = 0; i < 3; i++) sq_r[i] <= SQ_W'(mag_i[i]) * SQ_W'(mag_i[i]);
  end

  crg_meta_t         meta_r [ROOT_W+1];
  crg_mag_t          mag_r  [ROOT_W+1];
  logic [SUM_W-1:0]  sum_r  [ROOT_W+1];
  logic [REM_W-1:0]  rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] root_r [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r[0] <= '0;
    end else begin
      meta_r[0] <= mq_r;
    end
    mag_r[0]  <= gq_r;
    sum_r[0]  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    rem_r[0]  <= '0;
    root_r[0] <= '0;
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_digit
    logic [REM_W-1:0]  sh, trial, rem_nx;
    logic [ROOT_W-1:0] root_nx;

    always_comb begin
      sh    = {rem_r[j][REM_W-3:0], sum_r[j][SUM_W-1-2*j -: 2]};
      trial = {root_r[j], 2'b01};
      if (sh >= trial) begin
        rem_nx  = sh - trial;
        root_nx = {root_r[j][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nx  = sh;
        root_nx = {root_r[j][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        meta_r[j+1] <= '0;
      end else begin
        meta_r[j+1] <= meta_r[j];
      end
      mag_r[j+1]  <= mag_r[j];
      sum_r[j+1]  <= sum_r[j];
      rem_r[j+1]  <= rem_nx;
      root_r[j+1] <= root_nx;
    end
  end

  assign meta_o = meta_r[ROOT_W];
  assign mag_o  = mag_r[ROOT_W];
  assign root_o = root_r[ROOT_W];

endmodule

// ===== rtl/core/crg_div.sv =====
// Three-lane pipelined rounding divider, one quotient bit per stage.
module crg_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  crg_pkg::crg_meta_t                  meta_i,
  input  crg_pkg::crg_mag_t                   mag_i,
  input  logic [crg_pkg::ROOT_W-1:0]          root_i,
  output crg_pkg::crg_meta_t                  meta_o,
  output logic [2:0][crg_pkg::QUO_W-1:0]      quo_o
);
  import crg_pkg::*;

  localparam int NUM_W = MAG_W + FRAC_SH + 1;

  crg_meta_t               meta_r [QUO_W+1];
  logic [ROOT_W-1:0]       n_r    [QUO_W+1];
  logic [2:0][ROOT_W-1:0]  rem_r  [QUO_W+1];
  logic [2:0][QUO_W-1:0]   low_r  [QUO_W+1];
  logic [2:0][QUO_W-1:0]   quo_r  [QUO_W+1];
  logic [NUM_W-1:0]        num [3];

  // numerator |c|*2^14 + floor(n/2); its top bits already lie below n
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, mag_i[i], {FRAC_SH{1'b0}}} +
               {{(NUM_W-ROOT_W+1){1'b0}}, root_i[ROOT_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r[0] <= '0;
    end else begin
      meta_r[0] <= meta_i;
    end
    n_r[0] <= root_i;
    for (int i = 0; i < 3; i++) begin
      rem_r[0][i] <= ROOT_W'(num[i][NUM_W-1:QUO_W]);
      low_r[0][i] <= num[i][QUO_W-1:0];
      quo_r[0][i] <= '0;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [2:0][ROOT_W-1:0] rem_nx;
    logic [2:0][QUO_W-1:0]  quo_nx;
    logic [ROOT_W:0]        sh;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh = {rem_r[k][i], low_r[k][i][QUO_W-1-k]};
        if (sh >= {1'b0, n_r[k]}) begin
          rem_nx[i] = ROOT_W'(sh - {1'b0, n_r[k]});
          quo_nx[i] = {quo_r[k][i][QUO_W-2:0], 1'b1};
        end else begin
          rem_nx[i] = sh[ROOT_W-1:0];
          quo_nx[i] = {quo_r[k][i][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        meta_r[k+1] <= '0;
      end else begin
        meta_r[k+1] <= meta_r[k];
      end
      n_r[k+1]   <= n_r[k];
      low_r[k+1] <= low_r[k];
      rem_r[k+1] <= rem_nx;
      quo_r[k+1] <= quo_nx;
    end
  end

  assign meta_o = meta_r[QUO_W];
  assign quo_o  = quo_r[QUO_W];

endmodule

// ===== rtl/core/camera_ray_generator.sv =====
// Camera ray generator top level: registers, pipeline and result stage.
//
//   channel   ports                                   flow
//   request   start, busy, in_pixel_u, in_pixel_v     taken when start && !busy
//   result    out_valid, out_origin_*, out_dir_*      one-cycle strobe per ray
//   config    cfg_we, cfg_index, cfg_data             write on cfg_we, no wait
//
// From request to result a ray passes the front end (multiplies, origin, block
// normalization), the square root (one bit per stage), the dividers (one
// quotient bit per stage) and then the output register.
// One request is taken every cycle; busy stays low.
// Reset clears the configuration to its defaults and all valid bits.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module camera_ray_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [crg_pkg::UV_W-1:0]          in_pixel_u,
  input  logic [crg_pkg::UV_W-1:0]          in_pixel_v,
  input  logic                              cfg_we,
  input  logic [crg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crg_pkg::VEC_W-1:0]         cfg_data,
  output logic                              out_valid,
  output logic signed [crg_pkg::ORG_W-1:0]  out_origin_x,
  output logic signed [crg_pkg::ORG_W-1:0]  out_origin_y,
  output logic signed [crg_pkg::ORG_W-1:0]  out_origin_z,
  output logic signed [crg_pkg::DIR_W-1:0]  out_dir_x,
  output logic signed [crg_pkg::DIR_W-1:0]  out_dir_y,
  output logic signed [crg_pkg::DIR_W-1:0]  out_dir_z
);
  import crg_pkg::*;

  localparam int PIPE_LAT = 57;

  logic              mode_r;
  logic [VEC_W-1:0]  eye_r, view_r, right_r, up_r;
  logic [COMP_W-1:0] extent_r, focal_r;
  logic              in_fire;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      eye_r    <= '0;
      view_r   <= '0;
      right_r  <= '0;
      up_r     <= '0;
      extent_r <= EXTENT_RST;
      focal_r  <= FOCAL_RST;
    end else if (cfg_we) begin
      case (crg_reg_t'(cfg_index))
        REG_MODE:   mode_r   <= cfg_data[0];
        REG_EYE:    eye_r    <= cfg_data;
        REG_VIEW:   view_r   <= cfg_data;
        REG_RIGHT:  right_r  <= cfg_data;
        REG_UP:     up_r     <= cfg_data;
        REG_EXTENT: extent_r <= cfg_data[COMP_W-1:0];
        REG_FOCAL:  focal_r  <= cfg_data[COMP_W-1:0];
        default: ;
      endcase
    end
  end

  crg_meta_t               meta_f, meta_s, meta_d;
  crg_mag_t                mag_f, mag_s;
  logic [ROOT_W-1:0]       root_s;
  logic [2:0][QUO_W-1:0]   quo_d;

  crg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .pixel_u  (in_pixel_u),
    .pixel_v  (in_pixel_v),
    .persp    (mode_r),
    .eye      (eye_r),
    .view     (view_r),
    .right_ax (right_r),
    .up_ax    (up_r),
    .extent   (extent_r),
    .focal    (focal_r),
    .meta_o   (meta_f),
    .mag_o    (mag_f)
  );

  crg_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .meta_i (meta_f),
    .mag_i  (mag_f),
    .meta_o (meta_s),
    .mag_o  (mag_s),
    .root_o (root_s)
  );

  crg_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .meta_i (meta_s),
    .mag_i  (mag_s),
    .root_i (root_s),
    .meta_o (meta_d),
    .quo_o  (quo_d)
  );

  // pick ortho or normalized direction, apply sign, drop zero vectors
  logic [2:0][DIR_W-1:0] dir_nxt;
  logic [DIR_W-1:0]      qext;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qext = {1'b0, quo_d[i]};
      if (!meta_d.persp) begin
        dir_nxt[i] = meta_d.odir[i];
      end else if (meta_d.zero) begin
        dir_nxt[i] = '0;
      end else if (meta_d.neg[i]) begin
        dir_nxt[i] = -qext;
      end else begin
        dir_nxt[i] = qext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= meta_d.valid;
    end
    out_origin_x <= meta_d.origin[0];
    out_origin_y <= meta_d.origin[1];
    out_origin_z <= meta_d.origin[2];
    out_dir_x    <= dir_nxt[0];
    out_dir_y    <= dir_nxt[1];
    out_dir_z    <= dir_nxt[2];
  end

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##PIPE_LAT out_valid)
    else $error("request did not produce a ray after the pipeline latency");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, PIPE_LAT))
    else $error("ray produced without a matching request");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_x <= 16'sd16384 && out_dir_x >= -16'sd16384 &&
                   out_dir_y <= 16'sd16384 && out_dir_y >= -16'sd16384 &&
                   out_dir_z <= 16'sd16384 && out_dir_z >= -16'sd16384))
    else $error("direction component out of unit range");

endmodule

// ===== bench/tb_camera_ray_generator.sv =====
// Testbench for camera_ray_generator: directed rays, then random rays checked against a predictor.
`timescale 1ns / 1ps

module tb_camera_ray_generator;
  import crg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_RAYS  = 375;

  typedef struct {
    logic [2:0][ORG_W-1:0] org;
    logic [2:0][DIR_W-1:0] dir;
  } ray_t;

  typedef struct packed {
    logic [1:0]            stage;
    logic                  typed;
    logic [UV_W-1:0]       u;
    logic [UV_W-1:0]       v;
    logic [2:0][ORG_W-1:0] org;
    logic [2:0][DIR_W-1:0] dir;
  } dir_row_t;

  localparam dir_row_t ROWS [15] = '{
    // reset registers: all axes zero, so everything is zero
    '{2'd0, 1'b1, 17'd0,      17'd0,      '{3{24'd0}}, '{3{16'd0}}},
    '{2'd0, 1'b1, 17'd65536,  17'd65536,  '{3{24'd0}}, '{3{16'd0}}},
    '{2'd0, 1'b1, 17'd131071, 17'd131071, '{3{24'd0}}, '{3{16'd0}}},
    '{2'd0, 1'b1, 17'd32768,  17'd0,      '{3{24'd0}}, '{3{16'd0}}},
    // perspective with zero vectors: zero-length direction
    '{2'd1, 1'b1, 17'd0,      17'd0,      '{3{24'd0}}, '{3{16'd0}}},
    '{2'd1, 1'b1, 17'd131071, 17'd0,      '{3{24'd0}}, '{3{16'd0}}},
    // orthographic view saturation, eye at component extremes
    '{2'd2, 1'b1, 17'd0,      17'd131071, '{24'd1, 24'hFF8000, 24'd32767},
                                          '{16'd16384, 16'hC000, 16'd16384}},
    '{2'd2, 1'b1, 17'd65536,  17'd32768,  '{24'd1, 24'hFF8000, 24'd32767},
                                          '{16'd16384, 16'hC000, 16'd16384}},
    // perspective, plain camera
    '{2'd3, 1'b0, 17'd0,      17'd0,      '{3{24'd0}}, '{3{16'd0}}},
    '{2'd3, 1'b0, 17'd65536,  17'd0,      '{3{24'd0}}, '{3{16'd0}}},
    '{2'd3, 1'b0, 17'd0,      17'd65536,  '{3{24'd0}}, '{3{16'd0}}},
    '{2'd3, 1'b0, 17'd65536,  17'd65536,  '{3{24'd0}}, '{3{16'd0}}},
    '{2'd3, 1'b0, 17'd131071, 17'd131071, '{3{24'd0}}, '{3{16'd0}}},
    '{2'd3, 1'b0, 17'd32768,  17'd32768,  '{3{24'd0}}, '{3{16'd0}}},
    '{2'd3, 1'b0, 17'd1,      17'd131071, '{3{24'd0}}, '{3{16'd0}}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [UV_W-1:0] in_pixel_u = '0;
  logic [UV_W-1:0] in_pixel_v = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VEC_W-1:0] cfg_data = '0;
  logic out_valid;
  logic signed [ORG_W-1:0] out_origin_x, out_origin_y, out_origin_z;
  logic signed [DIR_W-1:0] out_dir_x, out_dir_y, out_dir_z;

  // shadow copy of the camera registers
  logic              persp_mode;
  logic [VEC_W-1:0]  eye_reg, view_reg, right_reg, up_reg;
  logic [COMP_W-1:0] extent_reg, focal_reg;

  ray_t pending_rays[$];
  int   mismatches = 0;
  int   cycles = 0;
  int   idle_pct = 0;

  camera_ray_generator u_top (.*);

  always #5 clk = ~clk;

  function automatic longint vcomp(logic [VEC_W-1:0] vec, int i);
    return longint'($signed(vec[COMP_W*i +: COMP_W]));
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  function automatic ray_t trace_ray(logic [UV_W-1:0] u, logic [UV_W-1:0] v);
    longint du, dv, e, f, o;
    longint off[3], d[3];
    longint unsigned mag[3], m, s, n, q;
    ray_t r;
    du = longint'(u) - 32768;
    dv = longint'(v) - 32768;
    e = longint'(extent_reg);
    f = longint'(focal_reg);
    for (int i = 0; i < 3; i++)
      off[i] = du * e * vcomp(right_reg, i) + dv * e * vcomp(up_reg, i);
    if (!persp_mode) begin
      for (int i = 0; i < 3; i++) begin
        o = (off[i] + (64'sd1 <<< 27)) >>> 28;
        r.org[i] = ORG_W'(clip(vcomp(eye_reg, i) + o, -8388608, 8388607));
        r.dir[i] = DIR_W'(clip(vcomp(view_reg, i) * 4, -16384, 16384));
      end
    end else begin
      m = 0;
      for (int i = 0; i < 3; i++) begin
        r.org[i] = ORG_W'(vcomp(eye_reg, i));
        d[i] = vcomp(view_reg, i) * f * 65536 + off[i];
        mag[i] = d[i] < 0 ? longint'(-d[i]) : longint'(d[i]);
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        for (int i = 0; i < 3; i++) r.dir[i] = '0;
      end else begin
        // bring the largest magnitude into [2^29, 2^30)
        while (m >= (64'd1 << 30)) begin
          m >>= 1;
          for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << 29)) begin
          m <<= 1;
          for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        s = 0;
        for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
        n = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
          q = ((mag[i] << 14) + (n >> 1)) / n;
          r.dir[i] = d[i] < 0 ? DIR_W'(-longint'(q)) : DIR_W'(q);
        end
      end
    end
    return r;
  endfunction

  task automatic report(string what, int i, longint got, longint want);
    $display("%0t: %s[%0d] got %0d want %0d", $time, what, i, got, want);
    mismatches++;
  endtask

  // check every result against the oldest pending ray
  always @(posedge clk) begin
    ray_t want;
    logic [2:0][ORG_W-1:0] got_org;
    logic [2:0][DIR_W-1:0] got_dir;
    if (rst_n && out_valid) begin
      got_org = {out_origin_z, out_origin_y, out_origin_x};
      got_dir = {out_dir_z, out_dir_y, out_dir_x};
      if (pending_rays.size() == 0) begin
        report("unrequested ray origin", 0, $signed(got_org[0]), 0);
      end else begin
        want = pending_rays.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got_org[i] !== want.org[i])
            report("origin", i, $signed(got_org[i]), $signed(want.org[i]));
          if (got_dir[i] !== want.dir[i])
            report("dir", i, $signed(got_dir[i]), $signed(want.dir[i]));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_camera_ray_generator NOT OK");
      $finish;
    end
  end

  // caller lowers cfg_we after the last write of a batch
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VEC_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_MODE:   persp_mode = data[0];
      REG_EYE:    eye_reg = data;
      REG_VIEW:   view_reg = data;
      REG_RIGHT:  right_reg = data;
      REG_UP:     up_reg = data;
      REG_EXTENT: extent_reg = data[COMP_W-1:0];
      REG_FOCAL:  focal_reg = data[COMP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_request(logic [UV_W-1:0] u, logic [UV_W-1:0] v, bit typed, ray_t fixed);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_pixel_u <= u;
    in_pixel_v <= v;
    do @(posedge clk); while (busy);
    pending_rays.push_back(typed ? fixed : trace_ray(u, v));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_rays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [VEC_W-1:0] pack3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  task automatic load_stage(logic [1:0] stage);
    case (stage)
      2'd1: write_reg(REG_MODE, 48'd1);
      2'd2: begin
        write_reg(REG_MODE, 48'd0);
        write_reg(REG_EYE, pack3(16'h7FFF, 16'h8000, 16'h0001));
        write_reg(REG_VIEW, pack3(16'h7FFF, 16'h8000, 16'h1000));
      end
      default: begin
        write_reg(REG_MODE, 48'd1);
        write_reg(REG_EYE, pack3(16'h1000, 16'h0000, 16'hF000));
        write_reg(REG_VIEW, pack3(16'h0000, 16'h0000, 16'hF000));
        write_reg(REG_RIGHT, pack3(16'h1000, 16'h0000, 16'h0000));
        write_reg(REG_UP, pack3(16'h0000, 16'h1000, 16'h0000));
        write_reg(REG_EXTENT, 48'h2000);
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  function automatic logic [COMP_W-1:0] rand_comp(int kind);
    logic [COMP_W-1:0] ext [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    case (kind)
      0: return COMP_W'($urandom);
      1: return ext[$urandom_range(0, 3)];
      default: return COMP_W'($urandom_range(0, 8192) - 4096);
    endcase
  endfunction

  function automatic logic [VEC_W-1:0] rand_vec();
    int kind;
    kind = $urandom_range(0, 3);
    return {rand_comp(kind), rand_comp(kind), rand_comp(kind)};
  endfunction

  function automatic logic [VEC_W-1:0] rand_scalar();
    case ($urandom_range(0, 4))
      0: return 48'd0;
      1: return 48'hFFFF;
      default: return VEC_W'({$urandom, $urandom});
    endcase
  endfunction

  task automatic random_camera();
    write_reg(REG_MODE, VEC_W'({$urandom, $urandom}));
    write_reg(REG_EYE, rand_vec());
    write_reg(REG_VIEW, rand_vec());
    write_reg(REG_RIGHT, rand_vec());
    write_reg(REG_UP, rand_vec());
    write_reg(REG_EXTENT, rand_scalar());
    write_reg(REG_FOCAL, rand_scalar());
    // unknown index must leave every register alone
    write_reg(REG_NONE, VEC_W'({$urandom, $urandom}));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [UV_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return UV_W'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? 17'd0 : 17'd65536;
      default: return UV_W'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    ray_t fixed;
    int   pcts [4] = '{0, 74, 0, 36};
    logic [1:0] stage;
    persp_mode = 1'b0;
    eye_reg = '0;
    view_reg = '0;
    right_reg = '0;
    up_reg = '0;
    extent_reg = EXTENT_RST;
    focal_reg = FOCAL_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    stage = 2'd0;
    foreach (ROWS[k]) begin
      if (ROWS[k].stage != stage) begin
        drain();
        stage = ROWS[k].stage;
        load_stage(stage);
      end
      fixed.org = ROWS[k].org;
      fixed.dir = ROWS[k].dir;
      send_request(ROWS[k].u, ROWS[k].v, ROWS[k].typed, fixed);
    end

    foreach (pcts[p]) begin
      idle_pct = pcts[p];
      for (int n = 0; n < PHASE_RAYS; n++) begin
        if (n % 125 == 0) begin
          drain();
          random_camera();
        end
        send_request(rand_coord(), rand_coord(), 1'b0, fixed);
      end
    end

    drain();
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_camera_ray_generator OK");
    end else begin
      $display("tb_camera_ray_generator NOT OK");
    end
    $finish;
  end

endmodule
